// File: sv/bst_pkg.sv
// Shared types and constants of the source tokenizer.
`default_nettype none

package bst_pkg;

    localparam int POS_W  = 16;
    localparam int LEN_W  = 8;
    localparam int CHAR_W = 8;
    localparam int KIND_W = 3;
    localparam int TAG_W  = 5;
    localparam int NUM_KW = 15;
    localparam int KW_CHARS = 5;
    localparam int NUM_SYM = 6;
    localparam int RES_MAX = 3;
    localparam int RES_CNT_W = 2;

    localparam logic [LEN_W-1:0]  MAX_TEXT_LEN = 8'd255;
    localparam logic [NUM_KW-1:0] KW_ALL       = '1;

    // token kinds
    localparam logic [KIND_W-1:0] K_NAME    = 3'd0;
    localparam logic [KIND_W-1:0] K_LABEL   = 3'd1;
    localparam logic [KIND_W-1:0] K_STRING  = 3'd2;
    localparam logic [KIND_W-1:0] K_INTEGER = 3'd3;
    localparam logic [KIND_W-1:0] K_SYMBOL  = 3'd4;
    localparam logic [KIND_W-1:0] K_EOL     = 3'd5;
    localparam logic [KIND_W-1:0] K_EOS     = 3'd6;
    localparam logic [KIND_W-1:0] K_ERROR   = 3'd7;

    localparam logic [TAG_W-1:0] TAG_NONE     = 5'd0;
    localparam logic [TAG_W-1:0] TAG_SYM_BASE = 5'd16;

    // special bytes
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h22;
    localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_COLON   = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_QUEST   = 8'h3F;

    // keywords, left justified, first character in the top byte
    localparam logic [8*KW_CHARS-1:0] KW_TEXT [NUM_KW] = '{
        "END  ", "FALSE", "FOR  ", "IF   ", "INPUT", "GOTO ", "LEN  ", "LEFT$",
        "LET  ", "NEXT ", "OR   ", "PRINT", "THEN ", "TO   ", "TRUE "
    };
    localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
        8'd3, 8'd5, 8'd3, 8'd2, 8'd5, 8'd4, 8'd3, 8'd5,
        8'd3, 8'd4, 8'd2, 8'd5, 8'd4, 8'd2, 8'd4
    };
    localparam logic [CHAR_W-1:0] SYM_CHARS [NUM_SYM] = '{"+", "=", "(", ")", ",", ";"};

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [POS_W-1:0]  first_row;
        logic [POS_W-1:0]  first_col;
        logic [POS_W-1:0]  stop_row;
        logic [POS_W-1:0]  stop_col;
        logic [LEN_W-1:0]  text_length;
        logic              last;
    } bst_result_t;

    typedef bst_result_t [RES_MAX-1:0] bst_result_vec_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0] count;
        bst_result_vec_t      data;
    } bst_push_t;

endpackage

`default_nettype wire

// File: sv/bst_lexer.sv
// Lexer state and the per-byte step that produces up to three results.
`default_nettype none

module bst_lexer
    import bst_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic [POS_W-1:0]  src_row,
    input  wire logic [POS_W-1:0]  src_col,
    output bst_push_t              push
);

    typedef enum logic [2:0] {
        MODE_START,
        MODE_NAME,
        MODE_STRING,
        MODE_INTEGER,
        MODE_SPACE,
        MODE_PEND
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic [KIND_W-1:0]  pend_reg, pend_next;
    logic [POS_W-1:0]   first_row_reg, first_row_next;
    logic [POS_W-1:0]   first_col_reg, first_col_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [NUM_KW-1:0]  kw_reg, kw_next;
    logic [TAG_W-1:0]   sym_reg, sym_next;
    logic               seen_reg, seen_next;
    logic               halted_reg, halted_next;

    logic [LEN_W-1:0]   len_inc;
    logic [NUM_KW-1:0]  narrow_cur;
    logic [NUM_KW-1:0]  narrow_first;
    logic [TAG_W-1:0]   kw_tag;
    logic [TAG_W-1:0]   sym_hit;
    logic               is_alpha, is_digit, is_suffix, is_blank;
    logic               to_start, err;
    logic [RES_CNT_W-1:0] n;
    bst_result_vec_t    res;
    logic [TAG_W-1:0]   emit_tag;

    // keywords whose character at position pos equals c
    function automatic logic [NUM_KW-1:0] kw_narrow(input logic [CHAR_W-1:0] c,
                                                    input logic [LEN_W-1:0]  pos);
        logic [NUM_KW-1:0] keep;
        keep = '0;
        for (int i = 0; i < NUM_KW; i++) begin
            if (pos < KW_LEN[i] &&
                KW_TEXT[i][8*(KW_CHARS-1-int'(pos[2:0])) +: 8] == c)
            begin
                keep[i] = 1'b1;
            end
        end
        return keep;
    endfunction

    // first remaining candidate of exactly this length
    function automatic logic [TAG_W-1:0] kw_find(input logic [NUM_KW-1:0] cand,
                                                 input logic [LEN_W-1:0]  len);
        logic [TAG_W-1:0] tag;
        tag = TAG_NONE;
        for (int i = NUM_KW - 1; i >= 0; i--) begin
            if (cand[i] && len == KW_LEN[i])
            begin
                tag = TAG_W'(i + 1);
            end
        end
        return tag;
    endfunction

    always_comb
    begin
        is_alpha  = (char_code >= "a" && char_code <= "z") ||
                    (char_code >= "A" && char_code <= "Z");
        is_digit  = char_code >= "0" && char_code <= "9";
        is_suffix = char_code == CH_DOLLAR || char_code == CH_QUEST ||
                    char_code == CH_PERCENT;
        is_blank  = char_code == CH_SPACE || char_code == CH_TAB;
        len_inc   = (len_reg < MAX_TEXT_LEN) ? len_reg + 8'd1 : len_reg;
        narrow_cur   = kw_narrow(char_code, len_reg);
        narrow_first = kw_narrow(char_code, '0);
        kw_tag       = kw_find(kw_reg, len_reg);
        sym_hit      = TAG_NONE;
        for (int i = 0; i < NUM_SYM; i++)
        begin
            if (SYM_CHARS[i] == char_code)
            begin
                sym_hit = TAG_SYM_BASE + TAG_W'(i);
            end
        end
    end

    always_comb
    begin
        mode_next      = mode_reg;
        pend_next      = pend_reg;
        first_row_next = first_row_reg;
        first_col_next = first_col_reg;
        len_next       = len_reg;
        kw_next        = kw_reg;
        sym_next       = sym_reg;
        seen_next      = seen_reg;
        halted_next    = halted_reg;
        res            = '0;
        n              = '0;
        to_start       = 1'b1;
        err            = 1'b0;
        emit_tag       = TAG_NONE;

        if (!halted_reg)
        begin
            // the flushed token is built from the stored state
            if (mode_reg == MODE_NAME || (mode_reg == MODE_PEND && pend_reg == K_NAME))
                emit_tag = kw_tag;
            else if (mode_reg == MODE_PEND && pend_reg == K_SYMBOL)
                emit_tag = sym_reg;

            unique case (mode_reg)
                MODE_NAME:
                begin
                    to_start = 1'b0;
                    if (is_alpha || is_digit)
                    begin
                        kw_next  = kw_reg & narrow_cur;
                        len_next = len_inc;
                    end
                    else if (is_suffix)
                    begin
                        kw_next   = kw_reg & narrow_cur;
                        len_next  = len_inc;
                        pend_next = K_NAME;
                        mode_next = MODE_PEND;
                    end
                    else if (char_code == CH_COLON)
                    begin
                        len_next  = len_inc;
                        pend_next = K_LABEL;
                        mode_next = MODE_PEND;
                    end
                    else
                    begin
                        res[n] = '{K_NAME, emit_tag, first_row_reg, first_col_reg,
                                   src_row, src_col, len_reg, 1'b0};
                        n = n + 2'd1;
                        seen_next = 1'b1;
                        mode_next = MODE_START;
                        to_start  = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    to_start = 1'b0;
                    if (char_code == CH_LF || char_code == CH_NUL)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        len_next = len_inc;
                        if (char_code == CH_QUOTE)
                        begin
                            pend_next = K_STRING;
                            mode_next = MODE_PEND;
                        end
                    end
                end
                MODE_INTEGER:
                begin
                    if (is_digit)
                    begin
                        len_next = len_inc;
                        to_start = 1'b0;
                    end
                    else
                    begin
                        res[n] = '{K_INTEGER, TAG_NONE, first_row_reg, first_col_reg,
                                   src_row, src_col, len_reg, 1'b0};
                        n = n + 2'd1;
                        seen_next = 1'b1;
                        mode_next = MODE_START;
                    end
                end
                MODE_SPACE:
                begin
                    if (is_blank)
                        to_start = 1'b0;
                    else
                        mode_next = MODE_START;
                end
                MODE_PEND:
                begin
                    res[n] = '{pend_reg, emit_tag, first_row_reg, first_col_reg,
                               src_row, src_col, len_reg, 1'b0};
                    n = n + 2'd1;
                    seen_next = 1'b1;
                    mode_next = MODE_START;
                end
                default:
                begin
                    mode_next = MODE_START;
                end
            endcase

            if (to_start && !err)
            begin
                first_row_next = src_row;
                first_col_next = src_col;
                len_next       = 8'd1;
                kw_next        = KW_ALL;
                sym_next       = TAG_NONE;
                if (char_code == CH_NUL)
                begin
                    if (seen_next)
                    begin
                        res[n] = '{K_EOL, TAG_NONE, '0, '0, '0, '0, '0, 1'b0};
                        n = n + 2'd1;
                    end
                    res[n] = '{K_EOS, TAG_NONE, '0, '0, '0, '0, '0, 1'b0};
                    n = n + 2'd1;
                    mode_next      = MODE_START;
                    pend_next      = K_NAME;
                    first_row_next = '0;
                    first_col_next = '0;
                    len_next       = '0;
                    seen_next      = 1'b0;
                    halted_next    = 1'b0;
                end
                else if (is_alpha)
                begin
                    kw_next   = narrow_first;
                    mode_next = MODE_NAME;
                end
                else if (char_code == CH_QUOTE)
                begin
                    mode_next = MODE_STRING;
                end
                else if (is_blank)
                begin
                    mode_next = MODE_SPACE;
                end
                else if (char_code == CH_LF)
                begin
                    pend_next = K_EOL;
                    mode_next = MODE_PEND;
                end
                else if (is_digit)
                begin
                    mode_next = MODE_INTEGER;
                end
                else if (sym_hit != TAG_NONE)
                begin
                    sym_next  = sym_hit;
                    pend_next = K_SYMBOL;
                    mode_next = MODE_PEND;
                end
                else
                begin
                    err = 1'b1;
                end
            end

            if (err)
            begin
                res[n] = '{K_ERROR, TAG_NONE, src_row, src_col, src_row, src_col, '0, 1'b0};
                n = n + 2'd1;
                halted_next = 1'b1;
            end

            if (n != '0)
                res[n - 2'd1].last = 1'b1;
        end

        push.count = step ? n : '0;
        push.data  = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_START;
            pend_reg      <= K_NAME;
            first_row_reg <= '0;
            first_col_reg <= '0;
            len_reg       <= '0;
            kw_reg        <= KW_ALL;
            sym_reg       <= TAG_NONE;
            seen_reg      <= 1'b0;
            halted_reg    <= 1'b0;
        end
        else if (step)
        begin
            mode_reg      <= mode_next;
            pend_reg      <= pend_next;
            first_row_reg <= first_row_next;
            first_col_reg <= first_col_next;
            len_reg       <= len_next;
            kw_reg        <= kw_next;
            sym_reg       <= sym_next;
            seen_reg      <= seen_next;
            halted_reg    <= halted_next;
        end
    end

    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        step && halted_reg |-> push.count == '0)
        else $error("result produced after syntax error");

    a_three_ends_source: assert property (@(posedge clk) disable iff (!rst_n)
        step && push.count == 2'd3 |-> push.data[2].kind == K_EOS && push.data[2].last)
        else $error("three results not ending in end of source");

    a_pend_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        step && !halted_reg && mode_reg == MODE_PEND |-> push.count != '0)
        else $error("pending token not flushed");

endmodule

`default_nettype wire

// File: sv/bst_result_fifo.sv
// Result queue: takes up to three results per cycle, delivers one per transfer.
`default_nettype none

module bst_result_fifo
    import bst_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire bst_push_t push,
    output logic           room,
    output logic           out_valid,
    input  wire logic      out_ready,
    output bst_result_t    out_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bst_result_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               pop;

    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // room for a whole run of results from one byte
    assign room      = count_reg <= CNT_W'(DEPTH - RES_MAX);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < RES_MAX; k++)
        begin
            if (RES_CNT_W'(k) < push.count)
                mem_reg[wr_ptr_reg + PTR_W'(k)] <= push.data[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.count);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_reg + CNT_W'(push.count) - CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != '0 |-> room)
        else $error("results pushed without room");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("pointers disagree on empty queue");

endmodule

`default_nettype wire

// File: sv/basic_source_tokenizer_core.sv
// Top level of the source tokenizer: input register, lexer step and result queue.
//
// Usage:
//   The slave channel takes one source byte per transfer with its row and column;
//   byte 0 ends a source. The master channel gives one token per transfer;
//   m_tlast marks the final token caused by a byte, m_tuser carries the kind.
//   A byte accepted into the input register is stepped by the lexer once the
//   result queue has room, and its tokens are written into the queue, whose
//   head drives m_tvalid. Throughput: one byte per cycle while each byte
//   yields at most one token and the receiver takes every token. A byte that
//   yields two or three tokens (end of source, flush plus error) holds up
//   the next byte while the extras drain through the single read port of the
//   four-entry result queue; the step only runs with room for three tokens.
//   When the receiver stalls, the queue fills and s_tready drops after the
//   input register holds a byte; nothing is lost.
//   After a syntax error every byte is taken and dropped until reset.
//   Reset (rst_n low, asynchronous) empties the queue and the input register
//   and returns the lexer to its start mode.
`default_nettype none

module basic_source_tokenizer_core
    import bst_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // char_code[7:0], src_row[23:8], src_col[39:24]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // token_tag[4:0], first_row[20:5], first_col[36:21],
                                        // stop_row[52:37], stop_col[68:53],
                                        // text_length[76:69], zeros[79:77]
    output logic [2:0]       m_tuser,   // token_kind[2:0]
    output logic             m_tlast    // last_of_run
);

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic [POS_W-1:0]  in_row_reg;
    logic [POS_W-1:0]  in_col_reg;
    logic              room;
    logic              advance;
    bst_push_t         push;
    bst_result_t       head;

    assign advance  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata[7:0];
            in_row_reg  <= s_tdata[23:8];
            in_col_reg  <= s_tdata[39:24];
        end
    end

    bst_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .char_code (in_char_reg),
        .src_row   (in_row_reg),
        .src_col   (in_col_reg),
        .push      (push)
    );

    bst_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tdata = {3'b000, head.text_length, head.stop_col, head.stop_row,
                      head.first_col, head.first_row, head.tag};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

`default_nettype wire

// File: verif/basic_source_tokenizer_core_tb.sv
// Testbench for basic_source_tokenizer_core: random sources checked against a predictor.
`timescale 1ns / 100ps

module basic_source_tokenizer_core_tb
    import bst_pkg::*;
();

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 20;

    // right-justified spellings for stimulus
    localparam bit [39:0] KEYWORD_SPELLING [15] = '{
        "END", "FALSE", "FOR", "IF", "INPUT", "GOTO", "LEN", "LEFT$",
        "LET", "NEXT", "OR", "PRINT", "THEN", "TO", "TRUE"
    };

    typedef enum logic [4:0] {
        TG_NONE, TG_END, TG_FALSE, TG_FOR, TG_IF, TG_INPUT, TG_GOTO, TG_LEN, TG_LEFT,
        TG_LET, TG_NEXT, TG_OR, TG_PRINT, TG_THEN, TG_TO, TG_TRUE,
        TG_PLUS, TG_EQUAL, TG_LPAREN, TG_RPAREN, TG_COMMA, TG_SEMI
    } token_tag_e;

    typedef enum logic [2:0] {
        LX_START, LX_NAME, LX_STRING, LX_DIGITS, LX_BLANK, LX_HELD
    } lex_mode_e;

    class token_ledger;
        lex_mode_e   mode;
        logic [2:0]  held_kind;
        logic [15:0] start_row;
        logic [15:0] start_col;
        int          text_len;
        logic [39:0] spelling;     // first five name bytes, right-justified
        token_tag_e  sym;
        bit          seen_token;
        bit          halted;
        bst_result_t tokens_due[$];
        bst_result_t batch[$];
        int          mismatches;

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            mode       = LX_START;
            held_kind  = K_NAME;
            start_row  = '0;
            start_col  = '0;
            text_len   = 0;
            spelling   = '0;
            sym        = TG_NONE;
            seen_token = 1'b0;
            halted     = 1'b0;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function token_tag_e symbol_tag(logic [7:0] c);
            case (c)
                "+":     return TG_PLUS;
                "=":     return TG_EQUAL;
                "(":     return TG_LPAREN;
                ")":     return TG_RPAREN;
                ",":     return TG_COMMA;
                ";":     return TG_SEMI;
                default: return TG_NONE;
            endcase
        endfunction

        function bit opens_token(logic [7:0] c);
            return is_letter(c) || is_digit(c) || c == CH_QUOTE || c == CH_SPACE ||
                   c == CH_TAB || c == CH_LF || c == CH_NUL || symbol_tag(c) != TG_NONE;
        endfunction

        function token_tag_e keyword_tag();
            case (spelling)
                "END":   return TG_END;
                "FALSE": return TG_FALSE;
                "FOR":   return TG_FOR;
                "IF":    return TG_IF;
                "INPUT": return TG_INPUT;
                "GOTO":  return TG_GOTO;
                "LEN":   return TG_LEN;
                "LEFT$": return TG_LEFT;
                "LET":   return TG_LET;
                "NEXT":  return TG_NEXT;
                "OR":    return TG_OR;
                "PRINT": return TG_PRINT;
                "THEN":  return TG_THEN;
                "TO":    return TG_TO;
                "TRUE":  return TG_TRUE;
                default: return TG_NONE;
            endcase
        endfunction

        function void add_result(logic [2:0] kind, logic [4:0] tag, logic [15:0] fr,
                                 logic [15:0] fc, logic [15:0] sr, logic [15:0] sc,
                                 logic [7:0] len);
            bst_result_t r;
            r.kind        = kind;
            r.tag         = tag;
            r.first_row   = fr;
            r.first_col   = fc;
            r.stop_row    = sr;
            r.stop_col    = sc;
            r.text_length = len;
            r.last        = 1'b0;
            batch = {batch, r};
        endfunction

        function void emit(logic [2:0] kind, logic [15:0] row, logic [15:0] col);
            token_tag_e tag;
            tag = TG_NONE;
            if (kind == K_NAME && text_len <= 5)
                tag = keyword_tag();
            else if (kind == K_SYMBOL)
                tag = sym;
            add_result(kind, tag, start_row, start_col, row, col, text_len[7:0]);
            seen_token = 1'b1;
            mode = LX_START;
        endfunction

        function void grow(logic [7:0] c, bit in_name);
            if (in_name && text_len < 5)
                spelling = {spelling[31:0], c};
            if (text_len < MAX_TEXT_LEN)
                text_len++;
        endfunction

        // one accepted source byte
        function void take_byte(logic [7:0] c, logic [15:0] row, logic [15:0] col);
            bit restart;
            bit fault;
            if (halted)
                return;
            restart = 1'b1;
            fault   = 1'b0;
            batch.delete();
            case (mode)
                LX_NAME:
                begin
                    restart = 1'b0;
                    if (is_letter(c) || is_digit(c))
                        grow(c, 1'b1);
                    else if (c == CH_DOLLAR || c == CH_QUEST || c == CH_PERCENT)
                    begin
                        grow(c, 1'b1);
                        held_kind = K_NAME;
                        mode = LX_HELD;
                    end
                    else if (c == CH_COLON)
                    begin
                        grow(c, 1'b0);
                        held_kind = K_LABEL;
                        mode = LX_HELD;
                    end
                    else
                    begin
                        emit(K_NAME, row, col);
                        restart = 1'b1;
                    end
                end
                LX_STRING:
                begin
                    restart = 1'b0;
                    if (c == CH_LF || c == CH_NUL)
                        fault = 1'b1;
                    else
                    begin
                        grow(c, 1'b0);
                        if (c == CH_QUOTE)
                        begin
                            held_kind = K_STRING;
                            mode = LX_HELD;
                        end
                    end
                end
                LX_DIGITS:
                begin
                    if (is_digit(c))
                    begin
                        grow(c, 1'b0);
                        restart = 1'b0;
                    end
                    else
                        emit(K_INTEGER, row, col);
                end
                LX_BLANK:
                begin
                    if (c == CH_SPACE || c == CH_TAB)
                        restart = 1'b0;
                    else
                        mode = LX_START;
                end
                LX_HELD: emit(held_kind, row, col);
                default: mode = LX_START;
            endcase

            if (restart && !fault)
            begin
                start_row = row;
                start_col = col;
                text_len  = 1;
                spelling  = '0;
                sym       = TG_NONE;
                if (c == CH_NUL)
                begin
                    if (seen_token)
                        add_result(K_EOL, TG_NONE, '0, '0, '0, '0, '0);
                    add_result(K_EOS, TG_NONE, '0, '0, '0, '0, '0);
                    clear();
                end
                else if (is_letter(c))
                begin
                    text_len = 0;
                    grow(c, 1'b1);
                    mode = LX_NAME;
                end
                else if (c == CH_QUOTE)
                    mode = LX_STRING;
                else if (c == CH_SPACE || c == CH_TAB)
                    mode = LX_BLANK;
                else if (c == CH_LF)
                begin
                    held_kind = K_EOL;
                    mode = LX_HELD;
                end
                else if (is_digit(c))
                    mode = LX_DIGITS;
                else
                begin
                    sym = symbol_tag(c);
                    if (sym != TG_NONE)
                    begin
                        held_kind = K_SYMBOL;
                        mode = LX_HELD;
                    end
                    else
                        fault = 1'b1;
                end
            end

            if (fault)
            begin
                add_result(K_ERROR, TG_NONE, row, col, row, col, '0);
                halted = 1'b1;
            end
            if (batch.size() != 0)
                batch[batch.size()-1].last = 1'b1;
            tokens_due = {tokens_due, batch};
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void match_token(bst_result_t got);
            bst_result_t want;
            if (tokens_due.size() == 0)
            begin
                $error("token with no byte behind it: kind %0d tag %0d", got.kind, got.tag);
                mismatches++;
                return;
            end
            want = tokens_due.pop_front();
            compare_field("token_kind", want.kind, got.kind);
            compare_field("token_tag", want.tag, got.tag);
            compare_field("first_row", want.first_row, got.first_row);
            compare_field("first_col", want.first_col, got.first_col);
            compare_field("stop_row", want.stop_row, got.stop_row);
            compare_field("stop_col", want.stop_col, got.stop_col);
            compare_field("text_length", want.text_length, got.text_length);
            compare_field("last_of_run", want.last, got.last);
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    token_ledger ledger;
    int          sent          = 0;
    int          cycles        = 0;
    int          send_idle_pct = 27;
    int          recv_idle_pct = 76;
    bit          stall_req     = 1'b0;

    basic_source_tokenizer_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [15:0] rand_pos();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [7:0] letter_byte();
        if ($urandom_range(0, 2) != 0)
            return 8'($urandom_range("A", "Z"));
        return 8'($urandom_range("a", "z"));
    endfunction

    function automatic logic [7:0] digit_byte();
        return 8'($urandom_range("0", "9"));
    endfunction

    function automatic logic [7:0] symbol_byte();
        case ($urandom_range(0, 5))
            0:       return "+";
            1:       return "=";
            2:       return "(";
            3:       return ")";
            4:       return ",";
            default: return ";";
        endcase
    endfunction

    // anything but the bytes that end or break a string
    function automatic logic [7:0] string_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_LF || c == CH_QUOTE);
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] c);
        logic [15:0] row;
        logic [15:0] col;
        row = rand_pos();
        col = rand_pos();
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {col, row, c};
        do
            @(posedge clk);
        while (!s_tready);
        ledger.take_byte(c, row, col);
        sent++;
    endtask

    task automatic send_word(input bit [39:0] w);
        for (int i = 4; i >= 0; i--)
            if (w[8*i +: 8] != 8'h00)
                send_byte(w[8*i +: 8]);
    endtask

    // stop offering and wait for every outstanding token
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (ledger.tokens_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_token();
        int pick;
        int tail;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            if ($urandom_range(0, 1) != 0)
                send_word(KEYWORD_SPELLING[$urandom_range(0, 14)]);
            else
            begin
                send_byte(letter_byte());
                repeat ($urandom_range(0, 5))
                    send_byte(($urandom_range(0, 2) != 0) ? letter_byte() : digit_byte());
            end
            tail = $urandom_range(0, 9);
            if (tail < 3)
            begin
                case ($urandom_range(0, 2))
                    0:       send_byte(CH_DOLLAR);
                    1:       send_byte(CH_QUEST);
                    default: send_byte(CH_PERCENT);
                endcase
            end
            else if (tail == 3)
                send_byte(CH_COLON);
            else if (tail == 4)
                send_byte(letter_byte());   // near miss on a keyword
        end
        else if (pick < 40)
        begin
            repeat ($urandom_range(1, 5))
                send_byte(digit_byte());
        end
        else if (pick < 52)
        begin
            send_byte(CH_QUOTE);
            repeat ($urandom_range(0, 8))
                send_byte(string_byte());
            send_byte(CH_QUOTE);
        end
        else if (pick < 67)
            send_byte(symbol_byte());
        else if (pick < 80)
        begin
            repeat ($urandom_range(1, 3))
                send_byte(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB);
        end
        else if (pick < 88)
            send_byte(CH_LF);
        else if (pick < 93)
            send_byte(CH_NUL);
        else
        begin
            // loose mix of bytes that can open a token
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 4))
                    0:       send_byte(letter_byte());
                    1:       send_byte(digit_byte());
                    2:       send_byte(symbol_byte());
                    3:       send_byte(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB);
                    default: send_byte(CH_LF);
                endcase
            end
        end
    endtask

    // receiver
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_req)
            begin
                m_tready <= 1'b0;
                stall_req = 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : collect
        bst_result_t got;
        got.kind        = m_tuser;
        got.tag         = m_tdata[4:0];
        got.first_row   = m_tdata[20:5];
        got.first_col   = m_tdata[36:21];
        got.stop_row    = m_tdata[52:37];
        got.stop_col    = m_tdata[68:53];
        got.text_length = m_tdata[76:69];
        got.last        = m_tlast;
        if (rst_n && m_tvalid && m_tready)
            ledger.match_token(got);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("FAIL basic_source_tokenizer_core");
            $finish;
        end
    end

    initial
    begin
        ledger = new();
        repeat (11)
            @(negedge clk);
        rst_n <= 1'b1;

        // directed: keyword with suffix, symbol, tab, label, string with 0xFF,
        // integer, newline, three-token flush at source end, empty source end
        send_word("LEFT$");
        send_byte("=");
        send_byte(CH_TAB);
        send_word("GO:");
        send_byte(CH_QUOTE);
        send_byte(8'hFF);
        send_byte(CH_QUOTE);
        send_byte("9");
        send_byte(CH_LF);
        send_word("OR");
        send_byte(CH_NUL);
        send_byte(CH_NUL);
        send_word("x%");
        send_byte(";");
        send_word("42");
        send_byte(CH_NUL);

        while (sent < 65)
            send_random_token();
        drain();

        send_idle_pct = 76;
        recv_idle_pct = 27;
        while (sent < 110)
            send_random_token();
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req = 1'b1;
        while (sent < 150)
            send_random_token();

        // syntax error last: the block stays halted until reset
        case ($urandom_range(0, 2))
            0:
            begin
                logic [7:0] bad;
                do
                    bad = 8'($urandom_range(1, 255));
                while (ledger.opens_token(bad));
                send_word("AB");
                send_byte(bad);
            end
            1:
            begin
                send_byte(CH_QUOTE);
                send_byte("x");
                send_byte(CH_LF);
            end
            default:
            begin
                send_byte(CH_QUOTE);
                send_byte("x");
                send_byte(CH_NUL);
            end
        endcase
        repeat (4)
            send_byte(8'($urandom_range(0, 255)));
        send_byte(CH_NUL);

        drain();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (ledger.mismatches == 0)
            $display("PASS basic_source_tokenizer_core");
        else
            $display("FAIL basic_source_tokenizer_core");
        $finish;
    end

endmodule

// File: sim.f
sv/bst_pkg.sv
sv/bst_lexer.sv
sv/bst_result_fifo.sv
sv/basic_source_tokenizer_core.sv
verif/basic_source_tokenizer_core_tb.sv
